/* rtl/priority_load_shed_controller_unit_macros.svh */
// Assertion macros for the priority load shed controller.
`ifndef PRIORITY_LOAD_SHED_CONTROLLER_UNIT_MACROS_SVH
`define PRIORITY_LOAD_SHED_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define PLSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plsc assertion failed");
// Next-cycle implication, disabled while reset is held.
`define PLSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plsc assertion failed");
`else
`define PLSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/plsc_pkg.sv */
// Package of types, codes and helper functions for the priority load shed controller.
`timescale 1ns / 1ps
`default_nettype none

package plsc_pkg;

  localparam int unsigned LOAD_W         = 5;
  localparam int unsigned LOAD_COUNT_DEF = 5;
  localparam int unsigned ACTION_W       = 2;
  localparam int unsigned IN_DATA_W      = 8;
  localparam int unsigned OUT_DATA_W     = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE      = 2'd0,
    ACT_RECONNECT = 2'd1,
    ACT_SHED      = 2'd2
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LOAD_W-1:0]   switches;
    logic                maintenance;
  } item_t;

  typedef struct packed {
    logic [LOAD_W-1:0] shed_mask;
    logic [LOAD_W-1:0] last_shed_mask;
    logic [LOAD_W-1:0] last_switches;
    logic              last_maintenance;
  } state_t;

  // Bit i is set when load i exists.
  function automatic logic [LOAD_W-1:0] load_mask(input int unsigned count);
    logic [LOAD_W-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < LOAD_W; i++) begin
      m[i] = (i < count);
    end
    return m;
  endfunction

  // One-hot of the highest set bit, zero when none is set.
  function automatic logic [LOAD_W-1:0] highest_bit(input logic [LOAD_W-1:0] v);
    logic [LOAD_W-1:0] h;
    logic              found;
    h     = '0;
    found = 1'b0;
    for (int i = LOAD_W - 1; i >= 0; i--) begin
      if (v[i] && !found) begin
        h[i]  = 1'b1;
        found = 1'b1;
      end
    end
    return h;
  endfunction

  // One-hot of the lowest set bit, zero when none is set.
  function automatic logic [LOAD_W-1:0] lowest_bit(input logic [LOAD_W-1:0] v);
    logic [LOAD_W-1:0] neg;
    neg = ~v + LOAD_W'(1);
    return v & neg;
  endfunction

endpackage

`default_nettype wire

/* rtl/plsc_step.sv */
// Combinational control pass: next shed state and the optional connected-load result.
`timescale 1ns / 1ps
`default_nettype none

module plsc_step #(
  parameter int unsigned LOAD_COUNT = plsc_pkg::LOAD_COUNT_DEF
) (
  input  wire plsc_pkg::item_t            item_i,
  input  wire plsc_pkg::state_t           state_i,
  output plsc_pkg::state_t                state_o,
  output logic                            emit_o,
  output logic [plsc_pkg::LOAD_W-1:0]     conn_o
);

  localparam logic [plsc_pkg::LOAD_W-1:0] LoadMask = plsc_pkg::load_mask(LOAD_COUNT);

  logic [plsc_pkg::LOAD_W-1:0] sw;
  logic [plsc_pkg::LOAD_W-1:0] conn_pre;
  logic [plsc_pkg::LOAD_W-1:0] shed_nxt;

  assign sw       = item_i.switches & LoadMask;
  assign conn_pre = sw & ~state_i.shed_mask & LoadMask;

  always_comb begin
    case (plsc_pkg::action_t'(item_i.action))
      plsc_pkg::ACT_RECONNECT: begin
        shed_nxt = state_i.shed_mask & ~plsc_pkg::highest_bit(state_i.shed_mask);
      end
      plsc_pkg::ACT_SHED: begin
        shed_nxt = state_i.shed_mask | plsc_pkg::lowest_bit(conn_pre);
      end
      default: begin
        shed_nxt = state_i.shed_mask;
      end
    endcase
    shed_nxt = shed_nxt & LoadMask;
  end

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    conn_o  = sw;
    if (item_i.maintenance) begin
      // Maintenance drives the switches straight through and forgets any shedding.
      if (!state_i.last_maintenance || (sw != state_i.last_switches)) begin
        emit_o                   = 1'b1;
        state_o.shed_mask        = '0;
        state_o.last_shed_mask   = '0;
        state_o.last_switches    = sw;
        state_o.last_maintenance = 1'b1;
      end
    end else begin
      state_o.shed_mask = shed_nxt;
      conn_o            = sw & ~shed_nxt & LoadMask;
      if ((shed_nxt != state_i.last_shed_mask) || (sw != state_i.last_switches) ||
          state_i.last_maintenance) begin
        emit_o                   = 1'b1;
        state_o.last_shed_mask   = shed_nxt;
        state_o.last_switches    = sw;
        state_o.last_maintenance = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/priority_load_shed_controller_unit.sv */
// Top level of the priority load shed controller: input stage, shed state and result register.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one control pass per transfer on the in_ channel and keeps
// track of which loads are shed. A pass in maintenance mode clears all shedding
// and drives the switch mask to the loads; a pass in normal mode may shed the
// lowest connected load or reconnect the highest shed one, and the loads driven
// are the switches less the shed ones. A result transfer on the out_ channel
// carries the connected-load mask and appears only when the mode, the switches
// or the shed mask differ from those of the previous result, so many passes
// give no result at all. Switch bits at or above LOAD_COUNT are treated as
// zero throughout. The block sustains one transfer per cycle in each
// direction while out_tready is held high: a pass is registered in the input
// stage on acceptance, worked out combinationally against the shed state,
// and its result is registered in the output register, from which it is
// offered on the out_ channel. The input stage and the output register
// together absorb a stall on the out_ side without losing a cycle, and
// in_tready follows out_tready combinationally when both stages are full.
// There is no configuration port.

`include "priority_load_shed_controller_unit_macros.svh"

module priority_load_shed_controller_unit #(
  parameter int unsigned LOAD_COUNT = plsc_pkg::LOAD_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // Fields from bit 0: action [1:0], switches [6:2], maintenance [7].
  input  wire logic [plsc_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // Fields from bit 0: connected_loads [4:0], zero fill [7:5].
  output logic [plsc_pkg::OUT_DATA_W-1:0]          out_tdata
);

  localparam logic [plsc_pkg::LOAD_W-1:0] LoadMask = plsc_pkg::load_mask(LOAD_COUNT);

  // Input stage holding the accepted pass.
  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  plsc_pkg::item_t             s1_item_r;
  plsc_pkg::item_t             in_item;

  // Shed state carried between passes.
  plsc_pkg::state_t            state_r;
  plsc_pkg::state_t            state_nxt;

  // Result register.
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [plsc_pkg::LOAD_W-1:0] out_data_r;

  logic                        emit;
  logic [plsc_pkg::LOAD_W-1:0] conn;
  logic                        s1_adv;
  logic                        in_xfer;

  // Unpack the input transfer, lowest field in the lowest bits.
  assign in_item.action      = in_tdata[plsc_pkg::ACTION_W-1:0];
  assign in_item.switches    = in_tdata[plsc_pkg::ACTION_W +: plsc_pkg::LOAD_W];
  assign in_item.maintenance = in_tdata[plsc_pkg::ACTION_W + plsc_pkg::LOAD_W];

  plsc_step #(
    .LOAD_COUNT (LOAD_COUNT)
  ) u_step (
    .item_i  (s1_item_r),
    .state_i (state_r),
    .state_o (state_nxt),
    .emit_o  (emit),
    .conn_o  (conn)
  );

  // The pass in the input stage completes once the result register can take
  // its result; a pass with no result uses the same slot for simplicity.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (s1_adv && emit) begin
      out_data_r <= conn;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(plsc_pkg::OUT_DATA_W - plsc_pkg::LOAD_W){1'b0}}, out_data_r};

  // A result never drives a load that does not exist.
  `PLSC_ASSERT_IMP(a_out_in_range, clk, rst_n, out_valid_r, (out_data_r & ~LoadMask) == '0)
  // While the last result came from maintenance, nothing may be shed.
  `PLSC_ASSERT_IMP(a_maint_no_shed, clk, rst_n, state_r.last_maintenance, state_r.shed_mask == '0)
  // The input side only stalls when a pass is held back in the input stage.
  `PLSC_ASSERT_IMP(a_stall_has_cause, clk, rst_n, !in_tready, s1_valid_r && out_valid_r)
  // A held pass stays in the input stage until it can complete.
  `PLSC_ASSERT_NXT(a_s1_hold, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r)

endmodule

`default_nettype wire
